// File: sv/mtb_pkg.sv
// shared types and constants for the multi timer bank
// no dependencies; used by mtb_slot_alu and multi_timer_bank_core
package mtb_pkg;

    localparam int NUM_TIMERS  = 16;
    localparam int COUNT_WIDTH = 32;
    localparam int PERIOD_W    = 32;
    localparam int ID_W        = $clog2(NUM_TIMERS);
    localparam int CNT_W       = $clog2(NUM_TIMERS + 1);

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_ALLOC   = 3'd1,
        OP_START   = 3'd2,
        OP_PAUSE   = 3'd3,
        OP_RESUME  = 3'd4,
        OP_RESTART = 3'd5,
        OP_RESIZE  = 3'd6,
        OP_STOP    = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BAD_ID = 2'd2
    } t_status;

    typedef enum logic {
        KIND_ACK    = 1'b0,
        KIND_EXPIRY = 1'b1
    } t_kind;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] count;
        logic [COUNT_WIDTH-1:0] period;
        logic                   en;
        logic                   pflag;
    } t_slot_cur;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] count;
        logic [COUNT_WIDTH-1:0] period;
        logic                   en;
        logic                   pflag;
        logic                   fire;
    } t_slot_upd;

endpackage

// File: sv/mtb_slot_alu.sv
// shared slot update unit: tick decrement, zero compare and reload, and command updates for one slot
// depends on mtb_pkg
module mtb_slot_alu (
    input  mtb_pkg::t_op                    i_op,
    input  mtb_pkg::t_slot_cur              i_cur,
    input  logic [mtb_pkg::COUNT_WIDTH-1:0] i_period,
    input  logic                            i_periodic,
    output mtb_pkg::t_slot_upd              o_upd
);

    logic w_zero;

    assign w_zero = (i_cur.count == '0);

    always_comb begin
        o_upd.count  = i_cur.count;
        o_upd.period = i_cur.period;
        o_upd.en     = i_cur.en;
        o_upd.pflag  = i_cur.pflag;
        o_upd.fire   = 1'b0;
        unique case (i_op)
            mtb_pkg::OP_TICK: begin
                if (i_cur.en) begin
                    if (w_zero) begin
                        o_upd.fire = 1'b1;
                        if (i_cur.pflag) begin
                            o_upd.count = i_cur.period;
                        end else begin
                            o_upd.en = 1'b0;
                        end
                    end else begin
                        o_upd.count = i_cur.count - 1'b1;
                    end
                end
            end
            mtb_pkg::OP_ALLOC: begin
                o_upd.en     = 1'b0;
                o_upd.pflag  = 1'b0;
                o_upd.period = i_period;
                o_upd.count  = i_period;
            end
            mtb_pkg::OP_START: begin
                o_upd.count = i_cur.period;
                o_upd.pflag = i_periodic;
                o_upd.en    = 1'b1;
            end
            mtb_pkg::OP_PAUSE: begin
                o_upd.en = 1'b0;
            end
            mtb_pkg::OP_RESUME: begin
                o_upd.en = 1'b1;
            end
            mtb_pkg::OP_RESTART: begin
                o_upd.count = i_cur.period;
            end
            mtb_pkg::OP_RESIZE: begin
                o_upd.period = i_period;
                o_upd.count  = i_period;
            end
            mtb_pkg::OP_STOP: begin
                o_upd.en    = 1'b0;
                o_upd.count = i_cur.period;
            end
            default: begin
                o_upd.fire = 1'b0;
            end
        endcase
    end

endmodule

// File: sv/multi_timer_bank_core.sv
// bank of down-counting timer slots with a single shared slot update unit
// depends on mtb_pkg and mtb_slot_alu
//
// usage:
//   input channel (i_in_valid / o_in_stall) carries one request: op, timer_id,
//   period, periodic. output channel (o_out_valid / i_out_stall) carries
//   results: kind, slot, status, last.
//   a command (allocate, start, pause, resume, restart, resize, stop) gives one
//   acknowledge with last set, written from S_CMD once the output is free.
//   a tick walks the allocated slots one per cycle through the shared unit,
//   pausing while an expiry waits on a stalled output; each expiring
//   slot gives an expiry result in slot order, the final one with last set,
//   and a tick with no expiry gives no result.
//   one request is handled at a time; o_in_stall stays high until the
//   request's last result is in the output register.
//   when the receiver stalls, the result register holds and the sequencer
//   waits before it needs the register again.
//   i_cfg_we writes the allocation limit r_limit (values above the bank size store the size).
//   reset clears all flags, the allocated count, and sets the limit to the
//   bank size; no clearing pass is needed.
module multi_timer_bank_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [2:0]                   i_op,
    input  logic [mtb_pkg::ID_W-1:0]     i_timer_id,
    input  logic [mtb_pkg::PERIOD_W-1:0] i_period,
    input  logic                         i_periodic,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_kind,
    output logic [mtb_pkg::ID_W-1:0]     o_slot,
    output logic [1:0]                   o_status,
    output logic                         o_last,
    input  logic                         i_cfg_we,
    input  logic [mtb_pkg::CNT_W-1:0]    i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMD,
        S_TICK,
        S_FLUSH
    } t_state;

    t_state                          r_state;
    mtb_pkg::t_op                    r_op;
    logic [mtb_pkg::ID_W-1:0]        r_id;
    logic [mtb_pkg::COUNT_WIDTH-1:0] r_period;
    logic                            r_pflag;
    logic [mtb_pkg::CNT_W-1:0]       r_idx;
    logic [mtb_pkg::CNT_W-1:0]       r_alloc;
    logic [mtb_pkg::CNT_W-1:0]       r_limit;
    logic                            r_pend;
    logic [mtb_pkg::ID_W-1:0]        r_pend_slot;

    logic                            r_out_vld;
    logic                            r_kind;
    logic [mtb_pkg::ID_W-1:0]        r_slot;
    logic [1:0]                      r_status;
    logic                            r_last;

    logic [mtb_pkg::NUM_TIMERS-1:0]  r_en;
    logic [mtb_pkg::NUM_TIMERS-1:0]  r_pfl;
    logic [mtb_pkg::COUNT_WIDTH-1:0] r_count  [mtb_pkg::NUM_TIMERS];
    logic [mtb_pkg::COUNT_WIDTH-1:0] r_period_st [mtb_pkg::NUM_TIMERS];

    logic                            w_out_free;
    logic                            w_out_load;
    logic [mtb_pkg::ID_W-1:0]        w_addr;
    mtb_pkg::t_op                    w_alu_op;
    mtb_pkg::t_slot_cur              w_cur;
    mtb_pkg::t_slot_upd              w_upd;
    logic                            w_in_range;
    logic                            w_cmd_ok;
    logic                            w_tick_wait;
    logic                            w_we;
    logic [mtb_pkg::CNT_W-1:0]       n_limit;

    assign w_out_free  = !r_out_vld || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_kind      = r_kind;
    assign o_slot      = r_slot;
    assign o_status    = r_status;
    assign o_last      = r_last;

    // slot selection for the shared unit
    always_comb begin
        if (r_state == S_TICK) begin
            w_addr   = r_idx[mtb_pkg::ID_W-1:0];
            w_alu_op = mtb_pkg::OP_TICK;
        end else if (r_op == mtb_pkg::OP_ALLOC) begin
            w_addr   = r_alloc[mtb_pkg::ID_W-1:0];
            w_alu_op = r_op;
        end else begin
            w_addr   = r_id;
            w_alu_op = r_op;
        end
    end

    assign w_cur.count  = r_count[w_addr];
    assign w_cur.period = r_period_st[w_addr];
    assign w_cur.en     = r_en[w_addr];
    assign w_cur.pflag  = r_pfl[w_addr];

    mtb_slot_alu u_alu (
        .i_op       (w_alu_op),
        .i_cur      (w_cur),
        .i_period   (r_period),
        .i_periodic (r_pflag),
        .o_upd      (w_upd)
    );

    assign w_in_range  = (r_idx < r_alloc);
    assign w_cmd_ok    = (r_op == mtb_pkg::OP_ALLOC) ? (r_alloc < r_limit)
                                                     : (mtb_pkg::CNT_W'(r_id) < r_alloc);
    assign w_tick_wait = w_upd.fire && r_pend && !w_out_free;
    assign w_we        = ((r_state == S_CMD) && w_out_free && w_cmd_ok)
                      || ((r_state == S_TICK) && w_in_range && !w_tick_wait);

    // result register load
    assign w_out_load  = ((r_state == S_CMD) && w_out_free)
                      || ((r_state == S_TICK) && w_in_range && !w_tick_wait
                          && w_upd.fire && r_pend)
                      || ((r_state == S_FLUSH) && r_pend && w_out_free);

    assign n_limit = (i_cfg_data > mtb_pkg::CNT_W'(mtb_pkg::NUM_TIMERS))
                   ? mtb_pkg::CNT_W'(mtb_pkg::NUM_TIMERS) : i_cfg_data;

    // slot stores
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_count[w_addr]     <= w_upd.count;
            r_period_st[w_addr] <= w_upd.period;
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_op     <= mtb_pkg::t_op'(i_op);
            r_id     <= i_timer_id;
            r_period <= i_period[mtb_pkg::COUNT_WIDTH-1:0];
            r_pflag  <= i_periodic;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_alloc     <= '0;
            r_limit     <= mtb_pkg::CNT_W'(mtb_pkg::NUM_TIMERS);
            r_pend      <= 1'b0;
            r_pend_slot <= '0;
            r_en        <= '0;
            r_pfl       <= '0;
            r_out_vld   <= 1'b0;
            r_kind      <= mtb_pkg::KIND_ACK;
            r_slot      <= '0;
            r_status    <= mtb_pkg::ST_OK;
            r_last      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= n_limit;
            end
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (w_we) begin
                r_en[w_addr]  <= w_upd.en;
                r_pfl[w_addr] <= w_upd.pflag;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_idx  <= '0;
                        r_pend <= 1'b0;
                        r_state <= (mtb_pkg::t_op'(i_op) == mtb_pkg::OP_TICK) ? S_TICK
                                                                               : S_CMD;
                    end
                end
                S_CMD: begin
                    if (w_out_free) begin
                        r_kind    <= mtb_pkg::KIND_ACK;
                        r_last    <= 1'b1;
                        if (!w_cmd_ok) begin
                            if (r_op == mtb_pkg::OP_ALLOC) begin
                                r_slot   <= '0;
                                r_status <= mtb_pkg::ST_FULL;
                            end else begin
                                r_slot   <= r_id;
                                r_status <= mtb_pkg::ST_BAD_ID;
                            end
                        end else begin
                            r_slot   <= w_addr;
                            r_status <= mtb_pkg::ST_OK;
                            if (r_op == mtb_pkg::OP_ALLOC) begin
                                r_alloc <= r_alloc + 1'b1;
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_TICK: begin
                    if (!w_in_range) begin
                        r_state <= S_FLUSH;
                    end else if (!w_tick_wait) begin
                        r_idx <= r_idx + 1'b1;
                        if (w_upd.fire) begin
                            if (r_pend) begin
                                r_kind    <= mtb_pkg::KIND_EXPIRY;
                                r_slot    <= r_pend_slot;
                                r_status  <= mtb_pkg::ST_OK;
                                r_last    <= 1'b0;
                            end
                            r_pend      <= 1'b1;
                            r_pend_slot <= w_addr;
                        end
                    end
                end
                S_FLUSH: begin
                    if (!r_pend) begin
                        r_state <= S_IDLE;
                    end else if (w_out_free) begin
                        r_kind    <= mtb_pkg::KIND_EXPIRY;
                        r_slot    <= r_pend_slot;
                        r_status  <= mtb_pkg::ST_OK;
                        r_last    <= 1'b1;
                        r_pend    <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_alloc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alloc <= mtb_pkg::CNT_W'(mtb_pkg::NUM_TIMERS))
        else $error("allocated count exceeds bank size");

    a_alloc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_alloc != $past(r_alloc)) |-> (r_alloc == $past(r_alloc) + 1'b1))
        else $error("allocated count moved by more than one");

    a_pend_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK && r_pend) |-> (mtb_pkg::CNT_W'(r_pend_slot) < r_idx))
        else $error("pending expiry not behind walk index");

    a_not_last_expiry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_last) |-> (r_kind == mtb_pkg::KIND_EXPIRY))
        else $error("acknowledge without last");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state != S_IDLE))
        else $error("request accepted but sequencer idle");

endmodule
